>>> design/ppu_pkg.sv
// Shared types, codes and helpers for the palette pixel unpacker.
// Used by ppu_front, ppu_back and the top level; depends on nothing else.
package ppu_pkg;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int COLOR_W  = 24;
    localparam int OFFSET_W = 3;
    localparam int COUNT_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int PIXEL_W  = 16;
    localparam int BPP_W    = 4;

    localparam int PALETTE_DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH           = 2;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd2;

    // Source formats.
    localparam logic [BPP_W-1:0] BPP_1     = 4'd1;
    localparam logic [BPP_W-1:0] BPP_4     = 4'd4;
    localparam logic [BPP_W-1:0] BPP_8     = 4'd8;
    localparam logic [BPP_W-1:0] BPP_RESET = BPP_8;

    typedef enum logic [1:0] {
        CMD_PALETTE = 2'd0,
        CMD_START   = 2'd1,
        CMD_BYTE    = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [INDEX_W-1:0]    palette_index;
        logic [COLOR_W-1:0]    palette_color;
        logic [OFFSET_W-1:0]   first_offset;
        logic [COUNT_W-1:0]    pixel_count;
        logic [BYTE_W-1:0]     image_byte;
    } cmd_t;

    // RGB888 to RGB565 by truncation of each channel.
    function automatic logic [PIXEL_W-1:0] to_rgb565(input logic [COLOR_W-1:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

>>> design/palette_pixel_unpacker_rgb565.sv
// Top level of the palette pixel unpacker: configuration register, front
// end and back end. Depends on ppu_pkg, ppu_front, ppu_back (and ppu_ram).
//
// Usage:
//   The input channel (s_valid/s_ready) takes one request per handshake:
//   a palette write (kind 0) loads one RGB888 color into the palette RAM,
//   a start (kind 1) sets the pixel count and the first-byte pixel offset,
//   and an image byte (kind 2) expands into 8, 2 or 1 pixels at 1, 4 or
//   8 bits per pixel, most significant pixel first, until the count runs out.
//   Each pixel leaves on the result channel (m_valid/m_ready) as RGB565 with
//   last_of_byte and run_done flags. bits_per_pixel is written through
//   cfg_we/cfg_wdata while the block is idle; it resets to 8.
//   Path: a request crosses a two-entry command queue, the command stage,
//   the palette read stage and the output register before the first pixel
//   of its byte appears on the result channel.
//   Rate: while the receiver takes every pixel, the back end emits one pixel
//   per cycle from the single palette read port; it takes each request in its
//   idle state, and a new byte only after the last pixel of the previous one.
//   When the receiver stalls, the output register and the read stage hold,
//   the back end stops, the queue fills and s_ready drops.
//   Reset clears the run state, the queue and all valids; the palette
//   contents stay undefined until written and need no clearing pass.
module palette_pixel_unpacker_rgb565 #(
    parameter int PALETTE_DEPTH = ppu_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ppu_pkg::BPP_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ppu_pkg::KIND_W-1:0]     s_kind,
    input  logic [ppu_pkg::INDEX_W-1:0]    s_palette_index,
    input  logic [ppu_pkg::COLOR_W-1:0]    s_palette_color,
    input  logic [ppu_pkg::OFFSET_W-1:0]   s_first_offset,
    input  logic [ppu_pkg::COUNT_W-1:0]    s_pixel_count,
    input  logic [ppu_pkg::BYTE_W-1:0]     s_image_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ppu_pkg::PIXEL_W-1:0]    m_pixel_rgb565,
    output logic                           m_last_of_byte,
    output logic                           m_run_done
);
    import ppu_pkg::*;

    // Source format register; the user changes it only while idle, which the block does not enforce.
    logic [BPP_W-1:0] bits_per_pixel_reg;

    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_per_pixel_reg <= BPP_RESET;
        end else if (cfg_we) begin
            bits_per_pixel_reg <= cfg_wdata;
        end
    end

    // The front end only classifies and queues; every state change that a
    // request causes happens in the back end, in request order.
    ppu_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .s_first_offset  (s_first_offset),
        .s_pixel_count   (s_pixel_count),
        .s_image_byte    (s_image_byte),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_ready       (cmd_ready)
    );

    ppu_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .bits_per_pixel (bits_per_pixel_reg),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_ready      (cmd_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_rgb565 (m_pixel_rgb565),
        .m_last_of_byte (m_last_of_byte),
        .m_run_done     (m_run_done)
    );

    // The pixel that empties the run is always the last one its byte gives.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_run_done) |-> m_last_of_byte)
        else $error("run_done without last_of_byte");

    // Right after reset the queue is empty and no pixel is pending.
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("queue or output not clear after reset");

    // Reset brings the format back to 8 bits per pixel.
    a_reset_bpp: assert property (@(posedge aclk)
        !aresetn |=> (bits_per_pixel_reg == BPP_RESET))
        else $error("bits_per_pixel not restored by reset");

endmodule

>>> design/ppu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the palette colors.
module ppu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ppu_front.sv
// Front end: accepts input requests, classifies them into commands and
// queues them for the back end. Depends on ppu_pkg.
module ppu_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ppu_pkg::KIND_W-1:0]     s_kind,
    input  logic [ppu_pkg::INDEX_W-1:0]    s_palette_index,
    input  logic [ppu_pkg::COLOR_W-1:0]    s_palette_color,
    input  logic [ppu_pkg::OFFSET_W-1:0]   s_first_offset,
    input  logic [ppu_pkg::COUNT_W-1:0]    s_pixel_count,
    input  logic [ppu_pkg::BYTE_W-1:0]     s_image_byte,
    output logic                           cmd_valid,
    output ppu_pkg::cmd_t                  cmd,
    input  logic                           cmd_ready
);
    import ppu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    cmd_t incoming;
    logic known_kind;
    logic push, pop;

    // Kind 3 carries no meaning: it is accepted and dropped here.
    always_comb begin
        incoming.palette_index = s_palette_index;
        incoming.palette_color = s_palette_color;
        incoming.first_offset  = s_first_offset;
        incoming.pixel_count   = s_pixel_count;
        incoming.image_byte    = s_image_byte;
        incoming.op            = CMD_PALETTE;
        known_kind             = 1'b1;
        unique case (s_kind)
            KIND_PALETTE: incoming.op = CMD_PALETTE;
            KIND_START:   incoming.op = CMD_START;
            KIND_BYTE:    incoming.op = CMD_BYTE;
            default:      known_kind  = 1'b0;
        endcase
    end

    assign s_ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    assign push = s_valid && s_ready && known_kind;
    assign pop  = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

>>> design/ppu_back.sv
// Back end: executes queued commands, holds the palette RAM and the run
// state, and expands image bytes into RGB565 pixels. Depends on ppu_pkg, ppu_ram.
module ppu_back #(
    parameter int PALETTE_DEPTH = ppu_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ppu_pkg::BPP_W-1:0]     bits_per_pixel,
    input  logic                          cmd_valid,
    input  ppu_pkg::cmd_t                 cmd,
    output logic                          cmd_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ppu_pkg::PIXEL_W-1:0]   m_pixel_rgb565,
    output logic                          m_last_of_byte,
    output logic                          m_run_done
);
    import ppu_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam logic [INDEX_W:0] DEPTH_LIM = (INDEX_W + 1)'(PALETTE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_EXPAND = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    pixels_left_reg, pixels_left_next;
    logic [OFFSET_W-1:0]   byte_offset_reg, byte_offset_next;
    logic [OFFSET_W-1:0]   pos_reg, pos_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;

    logic                  b_valid_reg, b_valid_next;
    logic                  b_oob_reg, b_last_reg, b_done_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0]    m_pixel_reg;
    logic                  m_last_reg, m_done_reg;

    logic                  ram_we, ram_re;
    logic [COLOR_W-1:0]    ram_rdata;
    logic [INDEX_W-1:0]    pix_index;
    logic [OFFSET_W-1:0]   end_pos, start_pos;
    logic                  bpp_known;
    logic [COUNT_W-1:0]    left_dec;
    logic                  pix_last, pix_done;
    logic                  issue, issue_ok, out_load;

    // Per-format start position, end position and index selection. The start
    // position comes from the run's start offset, which is cleared after the first byte.
    always_comb begin
        bpp_known = 1'b1;
        start_pos = '0;
        end_pos   = '0;
        pix_index = byte_reg;
        case (bits_per_pixel)
            BPP_1: begin
                start_pos = byte_offset_reg;
                end_pos   = OFFSET_W'(7);
                pix_index = {{(INDEX_W-1){1'b0}}, byte_reg[OFFSET_W'(7) - pos_reg]};
            end
            BPP_4: begin
                start_pos = {{(OFFSET_W-1){1'b0}}, byte_offset_reg[0]};
                end_pos   = OFFSET_W'(1);
                pix_index = pos_reg[0] ? {4'd0, byte_reg[3:0]} : {4'd0, byte_reg[7:4]};
            end
            BPP_8: begin
                start_pos = '0;
                end_pos   = '0;
                pix_index = byte_reg;
            end
            default: bpp_known = 1'b0;
        endcase
    end

    assign left_dec = pixels_left_reg - COUNT_W'(1);
    assign pix_done = (left_dec == '0);
    assign pix_last = (pos_reg == end_pos) || pix_done;

    assign out_load = b_valid_reg && (!m_valid_reg || m_ready);
    assign issue_ok = !b_valid_reg || out_load;

    always_comb begin
        state_next       = state_reg;
        pixels_left_next = pixels_left_reg;
        byte_offset_next = byte_offset_reg;
        pos_next         = pos_reg;
        byte_next        = byte_reg;
        cmd_ready        = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        issue            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    unique case (cmd.op)
                        CMD_PALETTE: ram_we = ({1'b0, cmd.palette_index} < DEPTH_LIM);
                        CMD_START: begin
                            byte_offset_next = cmd.first_offset;
                            pixels_left_next = cmd.pixel_count;
                        end
                        CMD_BYTE: begin
                            // Exhausted run or unknown format: the byte is dropped.
                            if (pixels_left_reg != '0 && bpp_known) begin
                                byte_next  = cmd.image_byte;
                                pos_next   = start_pos;
                                state_next = ST_EXPAND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXPAND: begin
                if (issue_ok) begin
                    issue            = 1'b1;
                    ram_re           = 1'b1;
                    pixels_left_next = left_dec;
                    pos_next         = pos_reg + OFFSET_W'(1);
                    if (pix_last) begin
                        byte_offset_next = '0;
                        state_next       = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (issue) begin
            b_valid_next = 1'b1;
        end else if (out_load) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    ppu_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd.palette_index[ADDR_W-1:0]),
        .wdata (cmd.palette_color),
        .re    (ram_re),
        .raddr (pix_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pixels_left_reg <= '0;
            byte_offset_reg <= '0;
            b_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pixels_left_reg <= pixels_left_next;
            byte_offset_reg <= byte_offset_next;
            b_valid_reg     <= b_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        byte_reg <= byte_next;
        if (issue) begin
            b_oob_reg  <= !({1'b0, pix_index} < DEPTH_LIM);
            b_last_reg <= pix_last;
            b_done_reg <= pix_done;
        end
        if (out_load) begin
            m_pixel_reg <= to_rgb565(b_oob_reg ? '0 : ram_rdata);
            m_last_reg  <= b_last_reg;
            m_done_reg  <= b_done_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_rgb565 = m_pixel_reg;
    assign m_last_of_byte = m_last_reg;
    assign m_run_done     = m_done_reg;

endmodule

>>> tb/sv/rgb565_pixel_checker.sv
// Pixel checker for the palette pixel unpacker: mirrors the palette and run
// state, predicts every RGB565 pixel and compares the result channel.
// Depends on ppu_pkg for field widths, request kinds and pixel formats.
`timescale 1ns / 1ps

module rgb565_pixel_checker
    import ppu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [BPP_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [INDEX_W-1:0]    s_palette_index,
    input  logic [COLOR_W-1:0]    s_palette_color,
    input  logic [OFFSET_W-1:0]   s_first_offset,
    input  logic [COUNT_W-1:0]    s_pixel_count,
    input  logic [BYTE_W-1:0]     s_image_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [PIXEL_W-1:0]    m_pixel_rgb565,
    input  logic                  m_last_of_byte,
    input  logic                  m_run_done,
    output int                    mismatches = 0,
    output int                    pixels_pending = 0
);

    typedef struct packed {
        logic [PIXEL_W-1:0] rgb;
        logic               last_of_byte;
        logic               run_done;
    } pixel_t;

    logic [COLOR_W-1:0]  palette_mirror [0:(2**INDEX_W)-1];
    logic [COUNT_W-1:0]  run_left   = '0;
    logic [OFFSET_W-1:0] run_offset = '0;
    logic [BPP_W-1:0]    bpp_mirror = BPP_RESET;
    pixel_t              expected_pixels [$];
    int                  mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                   input logic [PIXEL_W-1:0] want);
        $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // One pixel from the run: count it off, look up its color and truncate.
    task automatic emit_pixel(input logic [INDEX_W-1:0] index, input logic byte_end);
        logic [COLOR_W-1:0] c;
        pixel_t             p;
        run_left = run_left - 1'b1;
        c = palette_mirror[index];
        p.rgb          = {c[23:19], c[15:10], c[7:3]};
        p.run_done     = (run_left == '0);
        p.last_of_byte = byte_end || p.run_done;
        expected_pixels.push_back(p);
    endtask

    task automatic expand_image_byte(input logic [BYTE_W-1:0] b);
        int pos;
        if (run_left == '0) begin
            return;
        end
        case (bpp_mirror)
            BPP_1: begin
                for (pos = int'(run_offset); pos < 8 && run_left != '0; pos++) begin
                    emit_pixel({7'd0, b[7-pos]}, pos == 7);
                end
            end
            BPP_4: begin
                if (!run_offset[0]) begin
                    emit_pixel({4'd0, b[7:4]}, 1'b0);
                end
                if (run_left != '0) begin
                    emit_pixel({4'd0, b[3:0]}, 1'b1);
                end
            end
            BPP_8: begin
                emit_pixel(b, 1'b1);
            end
            default: begin
                return;
            end
        endcase
        run_offset = '0;
    endtask

    always @(posedge aclk) begin : track
        pixel_t want;
        if (!aresetn) begin
            expected_pixels.delete();
            run_left   = '0;
            run_offset = '0;
            bpp_mirror = BPP_RESET;
        end else begin
            // Results are checked before this edge's request is predicted; the
            // pipeline is too deep for a request to come out on its own edge.
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel with none expected", m_pixel_rgb565, '0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_rgb565 !== want.rgb) begin
                        report_mismatch("pixel_rgb565", m_pixel_rgb565, want.rgb);
                    end
                    if (m_last_of_byte !== want.last_of_byte) begin
                        report_mismatch("last_of_byte", PIXEL_W'(m_last_of_byte),
                                        PIXEL_W'(want.last_of_byte));
                    end
                    if (m_run_done !== want.run_done) begin
                        report_mismatch("run_done", PIXEL_W'(m_run_done),
                                        PIXEL_W'(want.run_done));
                    end
                end
            end
            if (cfg_we) begin
                bpp_mirror = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                case (s_kind)
                    KIND_PALETTE: palette_mirror[s_palette_index] = s_palette_color;
                    KIND_START: begin
                        run_offset = s_first_offset;
                        run_left   = s_pixel_count;
                    end
                    KIND_BYTE: expand_image_byte(s_image_byte);
                    default: ;
                endcase
            end
        end
        pixels_pending <= expected_pixels.size();
        mismatches     <= mismatch_count;
    end

endmodule

>>> tb/sv/palette_pixel_unpacker_rgb565_tb.sv
// Testbench top for palette_pixel_unpacker_rgb565: clock, reset, request
// stimulus, result back-pressure and the final verdict.
// Depends on ppu_pkg, the block itself and rgb565_pixel_checker.
`timescale 1ns / 1ps

module palette_pixel_unpacker_rgb565_tb;
    import ppu_pkg::*;

    // Kind code the block has no use for; such requests must vanish quietly.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // A pixel format outside the three supported ones, at the top of the field.
    localparam logic [BPP_W-1:0] BPP_TOP_UNKNOWN = 4'd15;
    // Cycles allowed after the last expected pixel before the block counts as
    // idle: queue, command stage, palette read and output register, with margin.
    localparam int DRAIN_CYCLES    = 16;
    // Requests in the random part; the directed part adds about 25 more.
    localparam int RANDOM_REQUESTS = 355;
    localparam int MAX_RUN_BYTES   = 24;
    localparam int MAX_IDLE        = 16;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we  = 1'b0;
    logic [BPP_W-1:0]      cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_kind = '0;
    logic [INDEX_W-1:0]    s_palette_index = '0;
    logic [COLOR_W-1:0]    s_palette_color = '0;
    logic [OFFSET_W-1:0]   s_first_offset = '0;
    logic [COUNT_W-1:0]    s_pixel_count = '0;
    logic [BYTE_W-1:0]     s_image_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIXEL_W-1:0]    m_pixel_rgb565;
    logic                  m_last_of_byte;
    logic                  m_run_done;

    int                    mismatches;
    int                    pixels_pending;

    // When set, neither side idles: back-to-back requests and no stalls.
    logic                  calm = 1'b0;
    // Pixel format the block was last given, so that image bytes only point at
    // palette entries that have been written.
    logic [BPP_W-1:0]      bpp_now = BPP_RESET;
    bit                    palette_loaded [0:(2**INDEX_W)-1];
    int unsigned           stall_left = 0;

    palette_pixel_unpacker_rgb565 i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .s_first_offset  (s_first_offset),
        .s_pixel_count   (s_pixel_count),
        .s_image_byte    (s_image_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_rgb565  (m_pixel_rgb565),
        .m_last_of_byte  (m_last_of_byte),
        .m_run_done      (m_run_done)
    );

    rgb565_pixel_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .s_first_offset  (s_first_offset),
        .s_pixel_count   (s_pixel_count),
        .s_image_byte    (s_image_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_rgb565  (m_pixel_rgb565),
        .m_last_of_byte  (m_last_of_byte),
        .m_run_done      (m_run_done),
        .mismatches      (mismatches),
        .pixels_pending  (pixels_pending)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop. The slowest correct run is about 405 requests, each with the
    // longest gap and up to eight pixels that each wait out the longest stall;
    // the timeout is set well above that.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result back-pressure. After every pixel taken, the receiver draws how
    // many cycles it holds m_ready low before taking the next one. The hold
    // also counts down while nothing is on offer, so stalls land on every
    // pipeline phase, including the cycle a pixel first shows up.
    always @(posedge aclk) begin : ready_gen
        int unsigned hold;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
            stall_left <= hold;
            m_ready    <= (hold == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offers one request and returns on the edge that accepts it. Valid is
    // lowered only when a gap is drawn, so back-to-back requests keep it high
    // without a drop inside the same time step.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [INDEX_W-1:0] index,
                                input logic [COLOR_W-1:0] color,
                                input logic [OFFSET_W-1:0] offset,
                                input logic [COUNT_W-1:0] count,
                                input logic [BYTE_W-1:0] data);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_kind          <= kind;
        s_palette_index <= index;
        s_palette_color <= color;
        s_first_offset  <= offset;
        s_pixel_count   <= count;
        s_image_byte    <= data;
        s_valid         <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // The wrappers fill the fields a kind does not use with random values, so
    // the block is shown that it must ignore them.
    task automatic write_palette(input logic [INDEX_W-1:0] index,
                                 input logic [COLOR_W-1:0] color);
        palette_loaded[index] = 1'b1;
        send_request(KIND_PALETTE, index, color, OFFSET_W'($urandom),
                     COUNT_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic start_run(input logic [OFFSET_W-1:0] offset,
                             input logic [COUNT_W-1:0] count);
        send_request(KIND_START, INDEX_W'($urandom), COLOR_W'($urandom), offset, count,
                     BYTE_W'($urandom));
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] data);
        send_request(KIND_BYTE, INDEX_W'($urandom), COLOR_W'($urandom),
                     OFFSET_W'($urandom), COUNT_W'($urandom), data);
    endtask

    // The register may only change while the block is idle: stop offering,
    // let every expected pixel drain, give the pipeline time to swallow any
    // bytes that produce nothing, and only then write.
    task automatic set_bpp(input logic [BPP_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        bpp_now = value;
    endtask

    // Random palette index at most top whose entry has been written. Entry 0 is
    // always written first, so the search ends.
    function automatic logic [INDEX_W-1:0] pick_loaded(input int top);
        int i;
        do begin
            i = $urandom_range(0, top);
        end while (!palette_loaded[i]);
        return i[INDEX_W-1:0];
    endfunction

    // Image byte whose every pixel, at the current format, names a written
    // palette entry. Under an unsupported format nothing is read, so any byte
    // will do.
    function automatic logic [BYTE_W-1:0] safe_byte();
        logic [INDEX_W-1:0] hi;
        logic [INDEX_W-1:0] lo;
        case (bpp_now)
            BPP_4: begin
                hi = pick_loaded(15);
                lo = pick_loaded(15);
                return {hi[3:0], lo[3:0]};
            end
            BPP_8:   return pick_loaded(255);
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int          phase;
        int          steps;
        int          k;
        int          random_count;
        int          roll;
        int          left;
        int          per;
        int          nbytes;
        bit          first;
        logic [BPP_W-1:0]    fmt;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. The block starts at 8 bits per pixel. Entries 0 and 1
        // cover every 1 bpp pixel; 15 and 240 give the nibble extremes.
        write_palette(8'd0,   24'h000000);
        write_palette(8'd1,   24'hffffff);
        write_palette(8'd15,  24'ha5c35a);
        write_palette(8'd240, 24'h5a3ca5);
        write_palette(8'd255, 24'h07f807);

        // At 8 bpp the offset is ignored; the third byte comes after the run
        // is used up and must give nothing.
        start_run(3'd7, 16'd2);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'hf0);
        send_request(KIND_UNUSED, 8'hff, 24'hffffff, 3'd7, 16'hffff, 8'hff);
        // Largest count; it is left unfinished and replaced by the next start.
        start_run(3'd0, 16'hffff);
        push_byte(8'h0f);

        // At 1 bpp the offset skips leading pixels of the first byte only, and
        // the run ends in the middle of the second byte.
        set_bpp(BPP_1);
        start_run(3'd5, 16'd10);
        push_byte(8'ha5);
        push_byte(8'h5a);
        push_byte(8'hff);

        // At 4 bpp only the low offset bit counts: odd skips the high nibble.
        set_bpp(BPP_4);
        start_run(3'd1, 16'd3);
        push_byte(8'hf0);
        push_byte(8'h0f);
        start_run(3'd6, 16'd1);
        push_byte(8'hf1);
        // A run of zero pixels draws nothing.
        start_run(3'd0, 16'd0);
        push_byte(8'h11);

        // An unsupported format makes image bytes vanish, run state untouched.
        set_bpp(BPP_TOP_UNKNOWN);
        start_run(3'd2, 16'd4);
        push_byte(8'hff);

        // Random part, in phases of one pixel format each. Most of it is well
        // formed runs with random content; the rest is palette updates, unused
        // kinds, stray bytes and runs cut short by the next start. Every
        // request sent here counts toward the total.
        random_count = 0;
        phase = 0;
        while (random_count < RANDOM_REQUESTS) begin
            phase++;
            case (phase % 4)
                1: fmt = BPP_1;
                2: fmt = BPP_4;
                3: fmt = BPP_8;
                default: begin
                    do begin
                        fmt = BPP_W'($urandom_range(0, 15));
                    end while (fmt == BPP_1 || fmt == BPP_4 || fmt == BPP_8);
                end
            endcase
            set_bpp(fmt);
            calm <= ($urandom_range(0, 3) == 0);
            steps = $urandom_range(35, 55);
            for (k = 0; k < steps && random_count < RANDOM_REQUESTS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    offset = OFFSET_W'($urandom);
                    roll = $urandom_range(0, 19);
                    if (roll == 0) begin
                        count = '0;
                    end else if (roll == 1) begin
                        count = COUNT_W'($urandom);
                    end else begin
                        count = COUNT_W'($urandom_range(1, 24));
                    end
                    start_run(offset, count);
                    random_count++;
                    // Send just enough bytes to use up the run, as far as the
                    // cap allows; a huge count is left hanging on purpose.
                    left = int'(count);
                    first = 1'b1;
                    nbytes = 0;
                    while (left != 0 && nbytes < MAX_RUN_BYTES) begin
                        if (bpp_now == BPP_1) begin
                            per = 8 - (first ? int'(offset) : 0);
                        end else if (bpp_now == BPP_4) begin
                            per = 2 - (first ? int'(offset[0]) : 0);
                        end else begin
                            per = 1;
                        end
                        left = (left > per) ? left - per : 0;
                        first = 1'b0;
                        nbytes++;
                        push_byte(safe_byte());
                        random_count++;
                    end
                    // Now and then a byte after the run is over.
                    if ($urandom_range(0, 3) == 0) begin
                        push_byte(safe_byte());
                        random_count++;
                    end
                end else if (roll < 85) begin
                    write_palette(INDEX_W'($urandom), COLOR_W'($urandom));
                    random_count++;
                end else if (roll < 92) begin
                    send_request(KIND_UNUSED, INDEX_W'($urandom), COLOR_W'($urandom),
                                 OFFSET_W'($urandom), COUNT_W'($urandom),
                                 BYTE_W'($urandom));
                    random_count++;
                end else begin
                    push_byte(safe_byte());
                    random_count++;
                end
            end
        end

        // Drain: every expected pixel must come out, then a quiet stretch in
        // which nothing more may appear.
        s_valid <= 1'b0;
        calm <= 1'b0;
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pixels_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
